FILE: hw/rtl/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: hw/rtl/cfsd_pkg.sv
package cfsd_pkg;

  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned TRL_BYTES = 4;
  localparam int unsigned WIN_BYTES = 4;

  localparam logic [31:0] CRC_ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;

  localparam logic [31:0] MAGIC_RST   = 32'h4700_0000;
  localparam logic [31:0] MAX_LEN_RST = 32'd1048576;
  localparam logic [7:0]  RSV_MASK_RST = 8'h06;

  typedef enum logic [1:0] {
    CFG_MAGIC    = 2'd0,
    CFG_MAX_LEN  = 2'd1,
    CFG_RSV_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_RESERVED = 3'd3,
    ST_CRC_BAD  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    status_e     status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] max_len;
    logic [7:0]  rsv_mask;
  } cfg_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cfsd_cfg_regs.sv
module cfsd_cfg_regs
  import cfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic    <= MAGIC_RST;
      cfg_q.max_len  <= MAX_LEN_RST;
      cfg_q.rsv_mask <= RSV_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:    cfg_q.magic    <= cfg_wdata_i;
        CFG_MAX_LEN:  cfg_q.max_len  <= cfg_wdata_i;
        CFG_RSV_MASK: cfg_q.rsv_mask <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/cfsd_in_stage.sv
module cfsd_in_stage
  import cfsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t data_o
);

  logic     valid_q;
  in_item_t data_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/cfsd_engine.sv
`include "assert_macros.svh"

module cfsd_engine
  import cfsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  input  in_item_t  item_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] window_q, window_d;
  logic [2:0]  fill_q, fill_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] trl_q, trl_d;

  logic        out_valid_q;
  out_item_t   out_q;
  logic        res_v;
  out_item_t   res;
  logic [7:0]  b;

  function automatic out_item_t status_item(status_e st, logic [7:0] ty,
                                            logic [7:0] fl, logic [31:0] len);
    out_item_t o;
    o.kind           = KIND_STATUS;
    o.out_byte       = 8'd0;
    o.status         = st;
    o.frame_type     = ty;
    o.frame_flags    = fl;
    o.payload_length = len;
    return o;
  endfunction

  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign b      = item_i.in_byte;

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    type_d   = type_q;
    flags_d  = flags_q;
    len_d    = len_q;
    left_d   = left_q;
    crc_d    = crc_q;
    trl_d    = trl_q;
    res_v    = 1'b0;
    res      = '0;
    if (take_o) begin
      if (item_i.cmd == CMD_END) begin
        window_d = '0;
        fill_d   = '0;
        if (phase_q != PH_HUNT) begin
          res_v   = 1'b1;
          res     = status_item(ST_TRUNC, type_q, flags_q, len_q);
          phase_d = PH_HUNT;
        end
      end else begin
        case (phase_q)
          PH_HEADER: begin
            crc_d = crc_byte(crc_q, b);
            if (idx_q == 3'd0) begin
              type_d = b;
            end else if (idx_q == 3'd1) begin
              flags_d = b;
            end else begin
              len_d = {len_q[23:0], b};
            end
            idx_d = idx_q + 3'd1;
            if (idx_q == 3'(HDR_BYTES - 1)) begin
              if (len_d > cfg_i.max_len) begin
                res_v    = 1'b1;
                res      = status_item(ST_TOO_LONG, type_d, flags_d, len_d);
                phase_d  = PH_HUNT;
                window_d = '0;
                fill_d   = '0;
              end else if ((flags_d & cfg_i.rsv_mask) != 8'd0) begin
                res_v    = 1'b1;
                res      = status_item(ST_RESERVED, type_d, flags_d, len_d);
                phase_d  = PH_HUNT;
                window_d = '0;
                fill_d   = '0;
              end else begin
                left_d  = len_d;
                idx_d   = '0;
                trl_d   = '0;
                phase_d = (len_d == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_d        = crc_byte(crc_q, b);
            left_d       = left_q - 32'd1;
            res_v        = 1'b1;
            res.kind     = KIND_PAYLOAD;
            res.out_byte = b;
            res.status   = ST_OK;
            if (left_q == 32'd1) begin
              idx_d   = '0;
              trl_d   = '0;
              phase_d = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            trl_d = {trl_q[23:0], b};
            idx_d = idx_q + 3'd1;
            if (idx_q == 3'(TRL_BYTES - 1)) begin
              res_v    = 1'b1;
              res      = status_item(((crc_q ^ CRC_ALL_ONES) == trl_d) ? ST_OK : ST_CRC_BAD,
                                     type_q, flags_q, len_q);
              phase_d  = PH_HUNT;
              window_d = '0;
              fill_d   = '0;
            end
          end
          default: begin
            window_d = {window_q[23:0], b};
            if (fill_q < 3'(WIN_BYTES)) begin
              fill_d = fill_q + 3'd1;
            end
            if (fill_d == 3'(WIN_BYTES) && window_d == cfg_i.magic) begin
              phase_d = PH_HEADER;
              idx_d   = '0;
              type_d  = '0;
              flags_d = '0;
              len_d   = '0;
              left_d  = '0;
              trl_d   = '0;
              crc_d   = CRC_ALL_ONES;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      fill_q      <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      if (take_o) begin
        out_valid_q <= res_v;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    type_q   <= type_d;
    flags_q  <= flags_d;
    len_q    <= len_d;
    crc_q    <= crc_d;
    trl_q    <= trl_d;
    if (take_o && res_v) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_fill_range, fill_q > 3'(WIN_BYTES))
  `ASSERT_NEVER(a_payload_left, phase_q == PH_PAYLOAD && left_q == 32'd0)
  `ASSERT_NEVER(a_hdr_idx, phase_q == PH_HEADER && idx_q >= 3'(HDR_BYTES))
  `ASSERT_NEVER(a_trl_idx, phase_q == PH_TRAILER && idx_q >= 3'(TRL_BYTES))
  `ASSERT_PROP(a_payload_out, take_o && phase_q == PH_PAYLOAD |=> out_valid_q)
  `ASSERT_NEVER(a_status_byte, out_valid_q && out_q.kind == KIND_STATUS && out_q.out_byte != 8'd0)

endmodule

FILE: hw/rtl/crc_framed_stream_deframer.sv
// Byte-stream deframer: hunts a 4-byte magic, parses type, flags and a
// big-endian 32-bit length, forwards payload bytes and checks a reflected
// CRC-32 over header and payload against a big-endian 4-byte trailer.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction carries
// a data byte or an end-of-stream mark. Output channel (out_valid_o/
// out_ready_i/out_data_o): payload bytes (kind 0) and one status per frame
// (kind 1). Magic and header/trailer bytes produce no output transaction.
// An accepted input passes the input register, then the result register.
// Throughput: one input byte per cycle unless a result waits untaken;
// the CRC byte update is combinational between the two registers.
// Receiver stall: the result register holds; one more input is taken into
// the input register, then in_ready_o drops until the result is taken.
// Reset: asynchronous, active low; block hunts for magic with an empty
// window, configuration returns to defaults (magic 0x47000000, max length
// 1 MiB, reserved mask 0x06). Config writes via cfg_we_i/cfg_idx_i/
// cfg_wdata_i take effect the next cycle; the user must make them while
// idle, and the block itself does not enforce this.
module crc_framed_stream_deframer
  import cfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cfg_t     cfg;
  logic     take;
  logic     item_valid;
  in_item_t item;

  cfsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cfsd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  cfsd_engine u_eng (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
